// ----- rtl/bus_address_decoder_frame_timer_core_assert.svh -----
// Assertion macros shared by the decoder modules.
`ifndef BUS_ADDRESS_DECODER_FRAME_TIMER_CORE_ASSERT_SVH
`define BUS_ADDRESS_DECODER_FRAME_TIMER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BADFT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BADFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/badft_pkg.sv -----
`default_nettype none

package badft_pkg;

    // Sizing of the memory and the video register window.
    localparam int MEM_DEPTH  = 65536;
    localparam int RAM_BYTES  = 8192;
    localparam int VIDEO_REGS = 8;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 16;
    localparam int CFG_AW = 2;

    localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // The bus address is folded onto the memory by a reciprocal multiply.
    // The quotient of a 16-bit address by the depth is small.
    localparam int MEM_QMAX = 65535 / MEM_DEPTH;
    localparam int MEM_QW   = (MEM_QMAX > 0) ? $clog2(MEM_QMAX + 1) : 1;
    localparam longint unsigned MEM_RECIP =
        ((64'd1 << 32) + 64'(MEM_DEPTH) - 64'd1) / 64'(MEM_DEPTH);
    localparam int MEM_RECIP_W = $clog2(MEM_RECIP + 1);
    localparam int MEM_PROD_W  = ADDR_W + MEM_RECIP_W;
    localparam logic [ADDR_W:0] MEM_DEPTH_C = (ADDR_W + 1)'(MEM_DEPTH);

    // Fixed port addresses.
    localparam logic [ADDR_W-1:0] IO_BASE       = 16'h4000;
    localparam logic [ADDR_W-1:0] KEYPAD_PORT0  = IO_BASE + 16'h0016;
    localparam logic [ADDR_W-1:0] KEYPAD_PORT1  = IO_BASE + 16'h0017;
    localparam logic [ADDR_W-1:0] SERIAL_STATUS = IO_BASE + 16'h0018;
    localparam logic [ADDR_W-1:0] SERIAL_DATA   = IO_BASE + 16'h0019;
    localparam logic [ADDR_W-1:0] RAM2_BASE     = 16'h6000;
    localparam logic [ADDR_W:0]   RAM1_END      = (ADDR_W + 1)'(RAM_BYTES);
    localparam logic [ADDR_W:0]   RAM2_END      = (ADDR_W + 1)'(32'h6000 + RAM_BYTES);

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] FRAME_PERIOD_RST = 16'd29780;
    localparam logic [CFG_W-1:0] VBLANK_START_RST = CFG_W'(29780 - 340 * 21 / 3);
    localparam logic [CFG_W-1:0] VIDEO_BASE_RST   = 16'h2000;
    localparam logic [CFG_W-1:0] VIDEO_MASK_RST   = 16'hE000;

    // Depth of the queue between decode and execute.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        TGT_MEMORY  = 3'd0,
        TGT_VIDEO   = 3'd1,
        TGT_KEYPAD  = 3'd2,
        TGT_SSTATUS = 3'd3,
        TGT_SDATA   = 3'd4,
        TGT_NONE    = 3'd5
    } target_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_FRAME_PERIOD = 2'd0,
        CFG_VBLANK_START = 2'd1,
        CFG_VIDEO_BASE   = 2'd2,
        CFG_VIDEO_MASK   = 2'd3
    } cfg_idx_t;

    // One decoded bus word on its way from decode to execute.
    typedef struct packed {
        target_t             target;
        logic [IDX_W-1:0]    reg_index;
        logic                forward_write;
        logic                read_notify;
        logic                vblank_begin;
        logic                vblank_end;
        logic                mem_we;
        logic                mem_re;
        logic [ADDR_W-1:0]   address;
        logic [MEM_QW-1:0]   mem_quot;
        logic [DATA_W-1:0]   write_data;
    } entry_t;

    // Remainder table for the video register index: entry x holds x mod VIDEO_REGS.
    typedef logic [IDX_W-1:0] vmod_tbl_t [128];

    function automatic vmod_tbl_t build_vmod_tbl();
        vmod_tbl_t t;
        for (int i = 0; i < 128; i++) begin
            t[i] = IDX_W'(i % VIDEO_REGS);
        end
        return t;
    endfunction

    localparam vmod_tbl_t VMOD_TBL = build_vmod_tbl();

    // Address modulo the register count, one nibble at a time from the top.
    function automatic logic [IDX_W-1:0] video_index(input logic [ADDR_W-1:0] addr);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int k = 3; k >= 0; k--) begin
            r = VMOD_TBL[{r, addr[4*k +: 4]}];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bus_address_decoder_frame_timer_core.sv -----
// Bus address decoder with frame timer.
// Each accepted word passes through the queue and then the output register.
// Throughput: one word per cycle; a four-entry queue between decode and
// the memory stage absorbs output stalls before input ready drops.
// Reset: rst_n clears the frame counter, queue and output valid and loads the
// configuration defaults; the memory is not cleared and is undefined until written.
`default_nettype none

module bus_address_decoder_frame_timer_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     command,
    input  wire logic [badft_pkg::ADDR_W-1:0]   address,
    input  wire logic [badft_pkg::DATA_W-1:0]   write_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          target,
    output logic [badft_pkg::IDX_W-1:0]         reg_index,
    output logic [badft_pkg::DATA_W-1:0]        rd_byte,
    output logic                                forward_write,
    output logic                                read_notify,
    output logic                                vblank_begin,
    output logic                                vblank_end,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [badft_pkg::CFG_AW-1:0]   cfg_index,
    input  wire logic [badft_pkg::CFG_W-1:0]    cfg_data
);

    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_empty;
    badft_pkg::entry_t  push_entry;
    badft_pkg::entry_t  head;

    // Decode and frame timing.
    badft_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue.
    badft_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty)
    );

    // Memory access and output register.
    badft_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (queue_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .target        (target),
        .reg_index     (reg_index),
        .rd_byte       (rd_byte),
        .forward_write (forward_write),
        .read_notify   (read_notify),
        .vblank_begin  (vblank_begin),
        .vblank_end    (vblank_end)
    );

endmodule

`default_nettype wire

// ----- rtl/badft_front.sv -----
`default_nettype none

module badft_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         command,
    input  wire logic [badft_pkg::ADDR_W-1:0]       address,
    input  wire logic [badft_pkg::DATA_W-1:0]       write_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [badft_pkg::CFG_AW-1:0]       cfg_index,
    input  wire logic [badft_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                               queue_full,
    output logic                                    push,
    output badft_pkg::entry_t                       push_entry
);

    `include "bus_address_decoder_frame_timer_core_assert.svh"

    logic [badft_pkg::CFG_W-1:0]  frame_period_reg;
    logic [badft_pkg::CFG_W-1:0]  vblank_start_reg;
    logic [badft_pkg::CFG_W-1:0]  video_base_reg;
    logic [badft_pkg::CFG_W-1:0]  video_mask_reg;
    logic [badft_pkg::CFG_W-1:0]  frame_count_reg;
    logic [badft_pkg::CFG_W-1:0]  frame_count_next;
    logic [badft_pkg::CFG_W-1:0]  count_inc;
    logic                         bus_cycle;
    logic                         hit_video;
    logic                         hit_keypad;
    logic                         hit_ram;
    logic [badft_pkg::IDX_W-1:0]  vidx;
    logic [badft_pkg::MEM_PROD_W-1:0] quot_prod;
    badft_pkg::cmd_t              cmd;

    assign cmd       = badft_pkg::cmd_t'(command);
    assign in_ready  = !queue_full;
    assign push      = in_valid && !queue_full;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_period_reg <= badft_pkg::FRAME_PERIOD_RST;
            vblank_start_reg <= badft_pkg::VBLANK_START_RST;
            video_base_reg   <= badft_pkg::VIDEO_BASE_RST;
            video_mask_reg   <= badft_pkg::VIDEO_MASK_RST;
        end
        else if (cfg_valid)
        begin
            unique case (badft_pkg::cfg_idx_t'(cfg_index))
                badft_pkg::CFG_FRAME_PERIOD: frame_period_reg <= cfg_data;
                badft_pkg::CFG_VBLANK_START: vblank_start_reg <= cfg_data;
                badft_pkg::CFG_VIDEO_BASE:   video_base_reg   <= cfg_data;
                badft_pkg::CFG_VIDEO_MASK:   video_mask_reg   <= cfg_data;
                default:                     frame_period_reg <= frame_period_reg;
            endcase
        end
    end

    // Address classification.
    assign hit_video  = (address & video_mask_reg) == video_base_reg;
    assign hit_keypad = (address == badft_pkg::KEYPAD_PORT0) ||
                        (address == badft_pkg::KEYPAD_PORT1);
    assign hit_ram    = ({1'b0, address} < badft_pkg::RAM1_END) ||
                        ((address >= badft_pkg::RAM2_BASE) &&
                         ({1'b0, address} < badft_pkg::RAM2_END));
    assign vidx       = badft_pkg::video_index(address);

    // Quotient of the address by the memory depth; the remainder is taken in execute.
    assign quot_prod = badft_pkg::MEM_PROD_W'(address) *
                       badft_pkg::MEM_PROD_W'(badft_pkg::MEM_RECIP);

    // Frame counter advances once per bus read or write.
    assign bus_cycle = push && ((cmd == badft_pkg::CMD_READ) || (cmd == badft_pkg::CMD_WRITE));
    assign count_inc = frame_count_reg + badft_pkg::CFG_W'(1);

    always_comb
    begin
        frame_count_next = frame_count_reg;
        if (bus_cycle)
        begin
            frame_count_next = (count_inc == frame_period_reg) ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
        end
    end

    // Decode of one bus word into a queue entry.
    always_comb
    begin
        push_entry               = '0;
        push_entry.target        = badft_pkg::TGT_NONE;
        push_entry.address       = address;
        push_entry.write_data    = write_data;
        push_entry.mem_quot      = quot_prod[32 +: badft_pkg::MEM_QW];
        push_entry.vblank_begin  = bus_cycle && (count_inc == vblank_start_reg);
        push_entry.vblank_end    = bus_cycle && (count_inc == frame_period_reg);
        unique case (cmd)
            badft_pkg::CMD_READ:
            begin
                priority if (hit_video)
                begin
                    push_entry.target      = badft_pkg::TGT_VIDEO;
                    push_entry.reg_index   = vidx;
                    push_entry.read_notify = vidx != '0;
                end
                else if (hit_keypad)
                begin
                    push_entry.target    = badft_pkg::TGT_KEYPAD;
                    push_entry.reg_index = badft_pkg::IDX_W'(address[0]);
                end
                else if (address == badft_pkg::SERIAL_STATUS)
                begin
                    push_entry.target = badft_pkg::TGT_SSTATUS;
                end
                else if (address == badft_pkg::SERIAL_DATA)
                begin
                    push_entry.target = badft_pkg::TGT_SDATA;
                end
                else
                begin
                    push_entry.target = badft_pkg::TGT_MEMORY;
                    push_entry.mem_re = 1'b1;
                end
            end
            badft_pkg::CMD_WRITE:
            begin
                priority if (hit_video)
                begin
                    push_entry.target        = badft_pkg::TGT_VIDEO;
                    push_entry.reg_index     = vidx;
                    push_entry.forward_write = 1'b1;
                end
                else if (hit_keypad)
                begin
                    push_entry.target        = badft_pkg::TGT_KEYPAD;
                    push_entry.reg_index     = badft_pkg::IDX_W'(address[0]);
                    push_entry.forward_write = 1'b1;
                end
                else if (hit_ram)
                begin
                    push_entry.target = badft_pkg::TGT_MEMORY;
                    push_entry.mem_we = 1'b1;
                end
                else if (address == badft_pkg::SERIAL_DATA)
                begin
                    push_entry.target        = badft_pkg::TGT_SDATA;
                    push_entry.forward_write = 1'b1;
                end
                else
                begin
                    push_entry.target = badft_pkg::TGT_NONE;
                end
            end
            badft_pkg::CMD_LOAD:
            begin
                push_entry.mem_we = 1'b1;
            end
            default:
            begin
                push_entry.target = badft_pkg::TGT_NONE;
            end
        endcase
    end

    // The end-of-frame flag always comes with a counter back at zero.
    `BADFT_ASSERT_NEXT(a_frame_wrap, clk, rst_n, push && push_entry.vblank_end,
        frame_count_reg == '0)
    // Image loads and idle cycles leave the counter alone.
    `BADFT_ASSERT_NEXT(a_count_hold, clk, rst_n, !bus_cycle, $stable(frame_count_reg))

endmodule

`default_nettype wire

// ----- rtl/badft_queue.sv -----
`default_nettype none

module badft_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire badft_pkg::entry_t  push_entry,
    output logic                    full,
    input  wire logic               pop,
    output badft_pkg::entry_t       head,
    output logic                    empty
);

    `include "bus_address_decoder_frame_timer_core_assert.svh"

    badft_pkg::entry_t                  slot_reg [badft_pkg::QUEUE_DEPTH];
    logic [badft_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [badft_pkg::QUEUE_AW-1:0]     wr_ptr_next;
    logic [badft_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [badft_pkg::QUEUE_AW-1:0]     rd_ptr_next;
    logic [badft_pkg::QUEUE_AW:0]       count_reg;
    logic [badft_pkg::QUEUE_AW:0]       count_next;

    assign full  = count_reg == (badft_pkg::QUEUE_AW + 1)'(badft_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (badft_pkg::QUEUE_AW + 1)'(push)
                                - (badft_pkg::QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `BADFT_ASSERT_SAME(a_no_overflow, clk, rst_n, push, !full)
    `BADFT_ASSERT_SAME(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

`default_nettype wire

// ----- rtl/badft_back.sv -----
`default_nettype none

module badft_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire badft_pkg::entry_t              head,
    input  wire logic                           empty,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          target,
    output logic [badft_pkg::IDX_W-1:0]         reg_index,
    output logic [badft_pkg::DATA_W-1:0]        rd_byte,
    output logic                                forward_write,
    output logic                                read_notify,
    output logic                                vblank_begin,
    output logic                                vblank_end
);

    `include "bus_address_decoder_frame_timer_core_assert.svh"

    logic [badft_pkg::DATA_W-1:0]   mem [badft_pkg::MEM_DEPTH];
    logic [badft_pkg::DATA_W-1:0]   rdata_reg;
    logic [badft_pkg::ADDR_W:0]     fold_base;
    logic [badft_pkg::ADDR_W:0]     fold_diff;
    logic [badft_pkg::MEM_AW-1:0]   mem_idx;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    badft_pkg::target_t             target_reg;
    logic [badft_pkg::IDX_W-1:0]    reg_index_reg;
    logic                           forward_write_reg;
    logic                           read_notify_reg;
    logic                           vblank_begin_reg;
    logic                           vblank_end_reg;
    logic                           mem_re_reg;

    // Take the next word whenever the output stage is free or being drained.
    assign pop = !empty && (!out_valid_reg || out_ready);

    // Address modulo the memory depth, from the quotient found in decode.
    assign fold_base = (badft_pkg::ADDR_W + 1)'(head.mem_quot * badft_pkg::MEM_DEPTH_C);
    assign fold_diff = {1'b0, head.address} - fold_base;
    assign mem_idx   = fold_diff[badft_pkg::MEM_AW-1:0];

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (pop && head.mem_we)
        begin
            mem[mem_idx] <= head.write_data;
        end
    end

    // Memory read port, registered.
    always_ff @(posedge clk)
    begin
        if (pop && head.mem_re)
        begin
            rdata_reg <= mem[mem_idx];
        end
    end

    // Output stage.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            target_reg        <= head.target;
            reg_index_reg     <= head.reg_index;
            forward_write_reg <= head.forward_write;
            read_notify_reg   <= head.read_notify;
            vblank_begin_reg  <= head.vblank_begin;
            vblank_end_reg    <= head.vblank_end;
            mem_re_reg        <= head.mem_re;
        end
    end

    assign out_valid     = out_valid_reg;
    assign target        = target_reg;
    assign reg_index     = reg_index_reg;
    assign rd_byte       = mem_re_reg ? rdata_reg : '0;
    assign forward_write = forward_write_reg;
    assign read_notify   = read_notify_reg;
    assign vblank_begin  = vblank_begin_reg;
    assign vblank_end    = vblank_end_reg;

    // Only memory reads carry data.
    `BADFT_ASSERT_SAME(a_rdata_zero, clk, rst_n,
        out_valid_reg && (target_reg != badft_pkg::TGT_MEMORY), rd_byte == '0)
    // A word is never taken while the output holds an unaccepted one.
    `BADFT_ASSERT_SAME(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, !pop)

endmodule

`default_nettype wire
